### hdl/scl_pkg.sv
// scl_pkg: types and constants shared by the shell command lexer
// no dependencies

package scl_pkg;

   localparam logic [1:0] KIND_WORD = 2'd0;
   localparam logic [1:0] KIND_OPER = 2'd1;
   localparam logic [1:0] KIND_SPEC = 2'd2;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_TWO    = 8'h32;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_BSL    = 8'h5C;
   localparam logic [7:0] CH_DQ     = 8'h22;
   localparam logic [7:0] CH_SQ     = 8'h27;

   // one window slot: byte plus presence
   typedef struct packed {
      logic       present;
      logic [7:0] ch;
   } slot_type;

   // decision made on the window head
   typedef struct packed {
      logic       close_word;   // emit bare end mark if a word is open
      logic [1:0] tok_len;      // token bytes to emit (0..3)
      logic [1:0] kind;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [2:0] consume;      // bytes dropped from the window
      logic       set_quote;
      logic       clr_quote;
      logic       quote_dbl;
   } action_type;

   // one result transaction
   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic [1:0] token_kind;
      logic       token_end;
      logic       out_last;
   } result_type;

   function automatic logic [4:0] hex_digit(input slot_type s);
      logic [7:0] c;
      c = s.ch;
      if (!s.present) return 5'd16;
      if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
      if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
      if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
      return 5'd16;
   endfunction

   function automatic logic is_octal(input slot_type s);
      return s.present && s.ch >= 8'h30 && s.ch <= 8'h37;
   endfunction

endpackage

### hdl/scl_if.sv
// scl_if: valid/ready channel interfaces for the shell command lexer
// depends on scl_pkg

interface scl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       in_last;
   modport source (output valid, output in_char, output in_last, input ready);
   modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface scl_rsp_if;
   logic                  valid;
   logic                  ready;
   scl_pkg::result_type   data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### hdl/shell_command_lexer.sv
// shell_command_lexer: top level, window, sequencer and output register
// depends on scl_pkg, scl_if, scl_decode
//
// Streaming shell command-line tokenizer. One byte is accepted per
// transaction; req_ready is low while the byte is worked off. A non-last
// byte that does not fill the four-byte window is only stored. Otherwise
// each head decision is made in the shared decode unit (ST_DECIDE), its
// results (end mark and up to three token bytes) are emitted in ST_EMIT,
// and the byte ends in ST_FLUSH. Results pass through a holding register
// so that the last result of a byte can carry out_last. A filling
// non-last byte makes one decision; a last byte drains the whole window,
// up to four decisions and the closing end mark. A stalled receiver holds
// the sequencer while the output register stays full.

module shell_command_lexer (
   input logic      clock,
   input logic      reset,
   scl_req_if.sink  req,
   scl_rsp_if.source rsp
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_EMIT   = 3'd2;
   localparam logic [2:0] ST_FINAL  = 3'd3;
   localparam logic [2:0] ST_FLUSH  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [7:0]        win_ff [4];
   logic [7:0]        win_in [4];
   logic [2:0]        cnt_ff, cnt_in;
   logic              quote_ff, quote_in, dbl_ff, dbl_in, word_ff, word_in;
   logic              last_ff, last_in;
   scl_pkg::action_type act, act_ff, act_in;
   logic [2:0]        pend_ff, pend_in;     // results left: bit per step
   logic [1:0]        step_ff, step_in;     // 0 = end mark, 1..3 token bytes
   logic              ovalid_ff, ovalid_in;
   scl_pkg::result_type odata_ff, odata_in;
   logic              hvalid_ff, hvalid_in;
   scl_pkg::result_type hold_ff, hold_in;
   scl_pkg::slot_type s0, s1, s2, s3;
   logic              out_free;
   logic              hold_free;

   assign s0 = '{present: cnt_ff > 3'd0, ch: win_ff[0]};
   assign s1 = '{present: cnt_ff > 3'd1, ch: win_ff[1]};
   assign s2 = '{present: cnt_ff > 3'd2, ch: win_ff[2]};
   assign s3 = '{present: cnt_ff > 3'd3, ch: win_ff[3]};

   scl_decode u_dec (
      .s0(s0), .s1(s1), .s2(s2), .s3(s3),
      .inside_quotes(quote_ff), .quote_is_double(dbl_ff), .act(act)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = ovalid_ff;
   assign rsp.data  = odata_ff;
   assign out_free  = !ovalid_ff || rsp.ready;
   assign hold_free = !hvalid_ff || out_free;

   // sequencer
   always_comb begin
      logic more;
      state_in = state_ff;
      win_in = win_ff;
      cnt_in = cnt_ff;
      quote_in = quote_ff; dbl_in = dbl_ff; word_in = word_ff;
      last_in = last_ff;
      act_in = act_ff;
      pend_in = pend_ff; step_in = step_ff;
      ovalid_in = ovalid_ff && !rsp.ready;
      odata_in = odata_ff;
      hvalid_in = hvalid_ff;
      hold_in = hold_ff;
      more = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (cnt_ff == 3'd4) begin
                  win_in[3] = req.in_char;
               end else begin
                  win_in[cnt_ff[1:0]] = req.in_char;
                  cnt_in = cnt_ff + 3'd1;
               end
               last_in = req.in_last;
               if (req.in_last || cnt_ff >= 3'd3) state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            act_in = act;
            if (act.set_quote) begin quote_in = 1'b1; dbl_in = act.quote_dbl; end
            if (act.clr_quote) quote_in = 1'b0;
            pend_in = {act.tok_len >= 2'd3, act.tok_len >= 2'd2, act.tok_len >= 2'd1};
            step_in = (act.close_word && word_ff) ? 2'd0 : 2'd1;
            // drop consumed bytes
            for (int i = 0; i < 4; i++) begin
               win_in[i] = (3'(i) + act.consume < 3'd4) ?
                           win_ff[2'(3'(i) + act.consume)] : 8'd0;
            end
            cnt_in = (act.consume >= cnt_ff) ? 3'd0 : cnt_ff - act.consume;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (step_ff == 2'd0) begin
               more = 1'b1;
            end else begin
               more = pend_ff[step_ff - 2'd1];
            end
            if (!more) begin
               state_in = (last_ff && cnt_ff != 3'd0) ? ST_DECIDE :
                          (last_ff ? ST_FINAL : ST_FLUSH);
            end else if (hold_free) begin
               // previous result moves on, new one waits in the holding register
               if (hvalid_ff) begin
                  ovalid_in = 1'b1;
                  odata_in = hold_ff;
               end
               hvalid_in = 1'b1;
               hold_in.out_last = 1'b0;
               if (step_ff == 2'd0) begin
                  hold_in.out_char = 8'd0; hold_in.char_valid = 1'b0;
                  hold_in.token_kind = scl_pkg::KIND_WORD;
                  hold_in.token_end = 1'b1;
                  word_in = 1'b0;
               end else begin
                  unique case (step_ff)
                     2'd1:    hold_in.out_char = act_ff.b0;
                     2'd2:    hold_in.out_char = act_ff.b1;
                     default: hold_in.out_char = act_ff.b2;
                  endcase
                  hold_in.char_valid = 1'b1;
                  hold_in.token_kind = act_ff.kind;
                  hold_in.token_end = (act_ff.kind != scl_pkg::KIND_WORD) &&
                                      (step_ff == 2'(act_ff.tok_len));
                  if (act_ff.kind == scl_pkg::KIND_WORD) word_in = 1'b1;
                  else word_in = 1'b0;
               end
               // third token byte is the end of a decision
               if (step_ff == 2'd3) begin
                  pend_in = 3'd0;
               end else begin
                  step_in = step_ff + 2'd1;
               end
            end
         end
         ST_FINAL: begin
            // close the word left open at end of line
            if (!word_ff) begin
               quote_in = 1'b0; dbl_in = 1'b0;
               state_in = ST_FLUSH;
            end else if (hold_free) begin
               if (hvalid_ff) begin
                  ovalid_in = 1'b1;
                  odata_in = hold_ff;
               end
               hvalid_in = 1'b1;
               hold_in = '{out_char: 8'd0, char_valid: 1'b0,
                           token_kind: scl_pkg::KIND_WORD, token_end: 1'b1,
                           out_last: 1'b0};
               word_in = 1'b0;
            end
         end
         ST_FLUSH: begin
            // the held result is the last one of this byte
            if (!hvalid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               ovalid_in = 1'b1;
               odata_in = hold_ff;
               odata_in.out_last = 1'b1;
               hvalid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= 3'd0;
         quote_ff <= 1'b0; dbl_ff <= 1'b0; word_ff <= 1'b0;
         ovalid_ff <= 1'b0;
         hvalid_ff <= 1'b0;
         last_ff <= 1'b0;
         for (int i = 0; i < 4; i++) win_ff[i] <= 8'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         quote_ff <= quote_in; dbl_ff <= dbl_in; word_ff <= word_in;
         ovalid_ff <= ovalid_in;
         hvalid_ff <= hvalid_in;
         last_ff <= last_in;
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
      pend_ff <= pend_in;
      step_ff <= step_in;
      odata_ff <= odata_in;
      hold_ff <= hold_in;
   end

`ifndef SYNTHESIS
   // no new byte accepted while results are being produced
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == ST_IDLE)
      else $error("ready outside idle");
   // window never overfills
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4) else $error("window count overflow");
   // quote state and open word clear after a last byte is done
   a_quote: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && last_ff) |-> !quote_ff && !word_ff)
      else $error("quote state left after end of line");
   // holding register is empty between bytes
   a_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !hvalid_ff)
      else $error("held result left in idle");
`endif

endmodule

### hdl/scl_decode.sv
// scl_decode: shared head-of-window decision unit, used once per head decision
// depends on scl_pkg

module scl_decode (
   input  scl_pkg::slot_type   s0,
   input  scl_pkg::slot_type   s1,
   input  scl_pkg::slot_type   s2,
   input  scl_pkg::slot_type   s3,
   input  logic                inside_quotes,
   input  logic                quote_is_double,
   output scl_pkg::action_type act
);

   logic [7:0] c, n1, n2;
   logic       p1, p2;
   logic [4:0] d1, d2;
   logic [7:0] oct;
   logic [7:0] esc;

   assign c  = s0.ch;
   assign n1 = s1.ch;
   assign n2 = s2.ch;
   assign p1 = s1.present;
   assign p2 = s2.present;
   assign d1 = scl_pkg::hex_digit(s2);
   assign d2 = scl_pkg::hex_digit(s3);

   // octal value of up to three digits, wrapped to 8 bits
   always_comb begin
      oct = {5'd0, n1[2:0]};
      if (scl_pkg::is_octal(s2)) begin
         oct = {2'd0, n1[2:0], n2[2:0]};
         if (scl_pkg::is_octal(s3)) oct = {n1[1:0], n2[2:0], s3.ch[2:0]};
      end
   end

   // single-letter escapes
   always_comb begin
      unique case (n1)
         8'h61:   esc = 8'd7;
         8'h62:   esc = 8'd8;
         8'h66:   esc = 8'd12;
         8'h6E:   esc = 8'd10;
         8'h72:   esc = 8'd13;
         8'h74:   esc = 8'd9;
         8'h76:   esc = 8'd11;
         default: esc = n1;
      endcase
   end

   always_comb begin
      act = '0;
      act.consume = 3'd1;
      act.kind = scl_pkg::KIND_WORD;
      act.b0 = c;
      act.tok_len = 2'd1;
      if (inside_quotes) begin
         priority if (quote_is_double && c == scl_pkg::CH_BSL) begin
            if (!p1) begin
               act.b0 = scl_pkg::CH_BSL;
            end else if (n1 == scl_pkg::CH_X) begin
               if (d1[4]) begin
                  act.b0 = scl_pkg::CH_X; act.consume = 3'd2;
               end else if (d2[4]) begin
                  act.b0 = {4'd0, d1[3:0]}; act.consume = 3'd3;
               end else begin
                  act.b0 = {d1[3:0], d2[3:0]}; act.consume = 3'd4;
               end
            end else if (scl_pkg::is_octal(s1)) begin
               act.b0 = oct;
               act.consume = !scl_pkg::is_octal(s2) ? 3'd2 :
                             (!scl_pkg::is_octal(s3) ? 3'd3 : 3'd4);
            end else begin
               act.b0 = esc; act.consume = 3'd2;
            end
         end else if (c == (quote_is_double ? scl_pkg::CH_DQ : scl_pkg::CH_SQ)) begin
            act.tok_len = 2'd0; act.clr_quote = 1'b1;
         end else begin
            act.b0 = c;
         end
      end else begin
         priority if (c == 8'h20 || c == 8'h09 || c == 8'h0A) begin
            act.tok_len = 2'd0; act.close_word = 1'b1;
         end else if (c == scl_pkg::CH_DOLLAR && p1 && n1 == scl_pkg::CH_QMARK) begin
            act.close_word = 1'b1; act.kind = scl_pkg::KIND_SPEC;
            act.tok_len = 2'd2; act.b1 = n1; act.consume = 3'd2;
         end else if (c == scl_pkg::CH_DQ || c == scl_pkg::CH_SQ) begin
            act.tok_len = 2'd0; act.set_quote = 1'b1;
            act.quote_dbl = (c == scl_pkg::CH_DQ);
         end else if ((c == scl_pkg::CH_AMP || c == scl_pkg::CH_PIPE) && p1 && n1 == c) begin
            act.close_word = 1'b1; act.kind = scl_pkg::KIND_OPER;
            act.tok_len = 2'd2; act.b1 = c; act.consume = 3'd2;
         end else if (c == scl_pkg::CH_PIPE) begin
            act.close_word = 1'b1; act.kind = scl_pkg::KIND_OPER;
         end else if (c == scl_pkg::CH_LT) begin
            act.close_word = 1'b1; act.kind = scl_pkg::KIND_OPER;
            act.consume = (p1 && n1 == scl_pkg::CH_LT) ? 3'd2 : 3'd1;
         end else if (c == scl_pkg::CH_GT) begin
            act.close_word = 1'b1; act.kind = scl_pkg::KIND_OPER;
            if (p1 && n1 == scl_pkg::CH_GT) begin
               act.tok_len = 2'd2; act.b1 = n1; act.consume = 3'd2;
            end
         end else if ((c == scl_pkg::CH_AMP || c == scl_pkg::CH_TWO) && p1
                      && n1 == scl_pkg::CH_GT) begin
            act.close_word = 1'b1; act.kind = scl_pkg::KIND_OPER;
            act.b1 = scl_pkg::CH_GT;
            if (p2 && n2 == scl_pkg::CH_GT) begin
               act.tok_len = 2'd3; act.b2 = scl_pkg::CH_GT; act.consume = 3'd3;
            end else begin
               act.tok_len = 2'd2; act.consume = 3'd2;
            end
         end else begin
            act.b0 = c;
         end
      end
   end

endmodule

### tb/scl_checker.sv
// scl_checker: watches both lexer channels, predicts the result stream and compares
// depends on scl_pkg and scl_if

module scl_checker (
   input  logic clock,
   input  logic reset,
   scl_req_if   req,
   scl_rsp_if   rsp,
   output int   fail_count,
   output int   pending
);

   localparam int NONE = 256;
   localparam int MAX_RES = 12;

   // lexer state mirror
   logic [7:0] win[4];
   int         win_cnt;
   bit         in_quote;
   bit         quote_dbl;
   bit         word_live;

   scl_pkg::result_type step_res[$];
   scl_pkg::result_type tokens_due[$];

   function automatic int peek_at(int k);
      return (k < win_cnt) ? int'(win[k]) : NONE;
   endfunction

   function automatic void push_res(int ch, bit vld, logic [1:0] kind, bit tend);
      scl_pkg::result_type r;
      if (step_res.size() >= MAX_RES) return;
      r.out_char   = ch[7:0];
      r.char_valid = vld;
      r.token_kind = kind;
      r.token_end  = tend;
      r.out_last   = 1'b0;
      step_res.push_back(r);
   endfunction

   function automatic void word_char(int ch);
      push_res(ch, 1'b1, scl_pkg::KIND_WORD, 1'b0);
      word_live = 1'b1;
   endfunction

   function automatic void end_word();
      if (word_live) push_res(0, 1'b0, scl_pkg::KIND_WORD, 1'b1);
      word_live = 1'b0;
   endfunction

   function automatic void put_token(int a, int b, int c, int len, logic [1:0] kind);
      end_word();
      push_res(a, 1'b1, kind, len == 1);
      if (len >= 2) push_res(b, 1'b1, kind, len == 2);
      if (len >= 3) push_res(c, 1'b1, kind, 1'b1);
   endfunction

   function automatic int hex_val(int c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return 16;
   endfunction

   function automatic bit oct_ok(int c);
      return c >= "0" && c <= "7";
   endfunction

   // backslash at the head inside double quotes
   function automatic int decode_escape();
      int n1, d1, d2, v, cnt;
      n1 = peek_at(1);
      if (n1 == NONE) begin
         word_char(scl_pkg::CH_BSL);
         return 1;
      end
      if (n1 == scl_pkg::CH_X) begin
         d1 = hex_val(peek_at(2));
         if (d1 > 15) begin
            word_char(scl_pkg::CH_X);
            return 2;
         end
         d2 = hex_val(peek_at(3));
         if (d2 > 15) begin
            word_char(d1);
            return 3;
         end
         word_char(d1 * 16 + d2);
         return 4;
      end
      if (oct_ok(n1)) begin
         cnt = 1;
         v = n1 - "0";
         while (cnt < 3 && oct_ok(peek_at(1 + cnt))) begin
            v = v * 8 + peek_at(1 + cnt) - "0";
            cnt++;
         end
         word_char(v & 255);
         return 1 + cnt;
      end
      case (n1)
         "a": v = 7;
         "b": v = 8;
         "f": v = 12;
         "n": v = 10;
         "r": v = 13;
         "t": v = 9;
         "v": v = 11;
         default: v = n1;
      endcase
      word_char(v);
      return 2;
   endfunction

   // one decision on the window head, returns bytes consumed
   function automatic int head_decide();
      int c, n1, n2;
      c  = peek_at(0);
      n1 = peek_at(1);
      n2 = peek_at(2);
      if (in_quote) begin
         if (quote_dbl && c == scl_pkg::CH_BSL) return decode_escape();
         if (c == (quote_dbl ? int'(scl_pkg::CH_DQ) : int'(scl_pkg::CH_SQ))) begin
            in_quote = 1'b0;
            return 1;
         end
         word_char(c);
         return 1;
      end
      if (c == " " || c == 9 || c == 10) begin
         end_word();
         return 1;
      end
      if (c == scl_pkg::CH_DOLLAR && n1 == scl_pkg::CH_QMARK) begin
         put_token(scl_pkg::CH_DOLLAR, scl_pkg::CH_QMARK, 0, 2, scl_pkg::KIND_SPEC);
         return 2;
      end
      if (c == scl_pkg::CH_DQ || c == scl_pkg::CH_SQ) begin
         in_quote = 1'b1;
         quote_dbl = (c == scl_pkg::CH_DQ);
         return 1;
      end
      if ((c == scl_pkg::CH_AMP || c == scl_pkg::CH_PIPE) && n1 == c) begin
         put_token(c, c, 0, 2, scl_pkg::KIND_OPER);
         return 2;
      end
      if (c == scl_pkg::CH_PIPE) begin
         put_token(scl_pkg::CH_PIPE, 0, 0, 1, scl_pkg::KIND_OPER);
         return 1;
      end
      if (c == scl_pkg::CH_LT) begin
         put_token(scl_pkg::CH_LT, 0, 0, 1, scl_pkg::KIND_OPER);
         return (n1 == scl_pkg::CH_LT) ? 2 : 1;
      end
      if (c == scl_pkg::CH_GT) begin
         if (n1 == scl_pkg::CH_GT) begin
            put_token(scl_pkg::CH_GT, scl_pkg::CH_GT, 0, 2, scl_pkg::KIND_OPER);
            return 2;
         end
         put_token(scl_pkg::CH_GT, 0, 0, 1, scl_pkg::KIND_OPER);
         return 1;
      end
      if ((c == scl_pkg::CH_AMP || c == scl_pkg::CH_TWO) && n1 == scl_pkg::CH_GT) begin
         if (n2 == scl_pkg::CH_GT) begin
            put_token(c, scl_pkg::CH_GT, scl_pkg::CH_GT, 3, scl_pkg::KIND_OPER);
            return 3;
         end
         put_token(c, scl_pkg::CH_GT, 0, 2, scl_pkg::KIND_OPER);
         return 2;
      end
      word_char(c);
      return 1;
   endfunction

   function automatic void drop_front(int k);
      if (k >= win_cnt) begin
         win_cnt = 0;
         return;
      end
      for (int i = 0; i < 4 - k; i++) win[i] = win[i + k];
      win_cnt -= k;
   endfunction

   function automatic void lex_byte(logic [7:0] ch, logic is_last);
      step_res.delete();
      if (win_cnt >= 4) win_cnt = 3;
      win[win_cnt] = ch;
      win_cnt++;
      if (is_last) begin
         while (win_cnt > 0) drop_front(head_decide());
         end_word();
         in_quote = 1'b0;
         quote_dbl = 1'b0;
      end else if (win_cnt >= 4) begin
         drop_front(head_decide());
      end
      if (step_res.size() > 0) step_res[step_res.size() - 1].out_last = 1'b1;
      foreach (step_res[i]) tokens_due.push_back(step_res[i]);
   endfunction

   // predict on request transactions, compare on result transactions
   always @(posedge clock) begin
      scl_pkg::result_type want;
      if (reset) begin
         win = '{default: 8'h00};
         win_cnt = 0;
         in_quote = 1'b0;
         quote_dbl = 1'b0;
         word_live = 1'b0;
         tokens_due.delete();
         fail_count <= 0;
      end else begin
         if (req.valid && req.ready) lex_byte(req.in_char, req.in_last);
         if (rsp.valid && rsp.ready) begin
            if (tokens_due.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result transaction %p", rsp.data);
               fail_count <= fail_count + 1;
            end else begin
               want = tokens_due.pop_front();
               if (rsp.data.out_char !== want.out_char ||
                   rsp.data.char_valid !== want.char_valid ||
                   rsp.data.token_kind !== want.token_kind ||
                   rsp.data.token_end !== want.token_end ||
                   rsp.data.out_last !== want.out_last) begin
                  if (fail_count < 10)
                     $display("result mismatch: expected %p, got %p", want, rsp.data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= tokens_due.size();
   end

endmodule

### tb/tb_shell_command_lexer.sv
// tb_shell_command_lexer: clock, reset, line stimulus and verdict for the lexer
// depends on scl_pkg, scl_if, shell_command_lexer and scl_checker

module tb_shell_command_lexer;

   localparam int WATCH_LIMIT = 3000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   src_idle;
   int   snk_idle;
   int   sent;
   int   stall;
   logic [7:0] line_q[$];

   scl_req_if req ();
   scl_rsp_if rsp ();

   shell_command_lexer i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   scl_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // receiver stalls at random
   always @(negedge clock) begin
      rsp.ready <= ($urandom_range(99) >= snk_idle);
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         stall <= 0;
      end else if (stall >= WATCH_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         stall <= stall + 1;
      end
   end

   task automatic send_byte(input logic [7:0] ch, input logic is_last);
      @(negedge clock);
      while ($urandom_range(99) < src_idle) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid = 1'b1;
      req.in_char = ch;
      req.in_last = is_last;
      do @(posedge clock); while (!req.ready);
      sent++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
   endtask

   // send the queued line, last flag on its final byte
   task automatic flush_line();
      foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1);
      line_q.delete();
   endtask

   task automatic send_line(input string s);
      add_text(s);
      flush_line();
   endtask

   function automatic logic [7:0] pick_letter();
      return 8'($urandom_range(25)) + "a";
   endfunction

   // random escape inside double quotes
   task automatic add_escape();
      string letters;
      string hexes;
      letters = "abfnrtv";
      hexes = "09afAFgz";
      line_q.push_back(scl_pkg::CH_BSL);
      case ($urandom_range(5))
         0: line_q.push_back(letters[$urandom_range(6)]);
         1: begin
            line_q.push_back(scl_pkg::CH_X);
            repeat ($urandom_range(2)) line_q.push_back(hexes[$urandom_range(7)]);
         end
         2: repeat ($urandom_range(3, 1)) line_q.push_back(8'($urandom_range(7)) + "0");
         3: line_q.push_back(scl_pkg::CH_DQ);
         4: line_q.push_back(scl_pkg::CH_BSL);
         default: line_q.push_back(8'($urandom));
      endcase
   endtask

   // line of random tokens, or noise
   task automatic random_line();
      int pieces;
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(8, 1)) line_q.push_back(8'($urandom));
         flush_line();
         return;
      end
      pieces = $urandom_range(6, 1);
      repeat (pieces) begin
         case ($urandom_range(11))
            0, 1: repeat ($urandom_range(5, 1)) line_q.push_back(pick_letter());
            2: add_text(" ");
            3: add_text("\t");
            4: begin
               string ops[11] = '{"&&", "||", "|", "<", ">", ">>", "&>", "&>>", "2>",
                                  "2>>", "<<"};
               add_text(ops[$urandom_range(10)]);
            end
            5: add_text($urandom_range(1) ? "$?" : "$x");
            6: begin
               line_q.push_back(scl_pkg::CH_SQ);
               repeat ($urandom_range(4)) begin
                  if ($urandom_range(3) == 0) line_q.push_back(scl_pkg::CH_DQ);
                  else line_q.push_back(8'($urandom));
               end
               if ($urandom_range(4) != 0) line_q.push_back(scl_pkg::CH_SQ);
            end
            7, 8: begin
               line_q.push_back(scl_pkg::CH_DQ);
               repeat ($urandom_range(3)) begin
                  case ($urandom_range(3))
                     0, 1: add_escape();
                     2: line_q.push_back(scl_pkg::CH_SQ);
                     default: line_q.push_back(pick_letter());
                  endcase
               end
               if ($urandom_range(4) != 0) line_q.push_back(scl_pkg::CH_DQ);
               else if ($urandom_range(1)) line_q.push_back(scl_pkg::CH_BSL);
            end
            9: add_text($urandom_range(1) ? "&" : "2");
            10: add_text("\n");
            default: line_q.push_back(8'($urandom));
         endcase
      end
      flush_line();
   endtask

   task automatic drain_results();
      @(negedge clock);
      req.valid = 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.in_char = 8'h00;
      req.in_last = 1'b0;
      rsp.ready = 1'b0;
      src_idle = 0;
      snk_idle = 0;
      sent = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed lines: operators, special token, quoting and escapes
      send_line("ls -l && a||b | c < d > e >> f &> g &>> h 2> i 2>> j");
      send_line("cat << x $? $y & 2 z");
      send_line("'a\"b' \"c'd\" \"\" x");
      send_line("\"\\a\\b\\f\\n\\r\\t\\v\\x41\\x4 \\xg\\101\\777\\7q\\\\\\q\"");
      send_line("\"ab\\");
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b1);
      send_line("x");
      drain_results();

      // random lines in three idling phases
      src_idle = 36;
      snk_idle = 65;
      while (sent < 230) random_line();
      drain_results();
      src_idle = 65;
      snk_idle = 36;
      while (sent < 365) random_line();
      drain_results();
      src_idle = 0;
      snk_idle = 0;
      while (sent < 500) random_line();
      drain_results();
      repeat (40) @(posedge clock);

      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
